// ----- rtl/core/ltdst_pkg.sv -----
package ltdst_pkg;

  localparam logic [10:0] MinPerHour = 11'd60;
  localparam logic [12:0] MinPerDay  = 13'd1440;
  localparam logic [13:0] YearMin    = 14'd1970;
  localparam logic [13:0] YearMax    = 14'd9999;
  localparam logic [10:0] TzLimit    = 11'd840;
  localparam logic [8:0]  DaysBase   = 9'd31;
  localparam logic [2:0]  InstLast   = 3'd4;
  localparam logic [3:0]  MonthLast  = 4'd11;
  localparam logic [2:0]  WdNone     = 3'd7;
  localparam logic [12:0] Recip100   = 13'd5243;
  localparam int          Shift100   = 19;
  localparam logic [13:0] Recip7     = 14'd9362;
  localparam int          Shift7     = 16;

  localparam logic [2:0] CfgTzOffset  = 3'd0;
  localparam logic [2:0] CfgDstEnable = 3'd1;
  localparam logic [2:0] CfgStartMon  = 3'd2;
  localparam logic [2:0] CfgStartWd   = 3'd3;
  localparam logic [2:0] CfgStartInst = 3'd4;
  localparam logic [2:0] CfgEndMon    = 3'd5;
  localparam logic [2:0] CfgEndWd     = 3'd6;
  localparam logic [2:0] CfgEndInst   = 3'd7;

  typedef struct packed {
    logic signed [10:0] tz_offset_minutes;
    logic               dst_enable;
    logic [3:0]         dst_start_month;
    logic [2:0]         dst_start_weekday;
    logic [2:0]         dst_start_instance;
    logic [3:0]         dst_end_month;
    logic [2:0]         dst_end_weekday;
    logic [2:0]         dst_end_instance;
  } cfg_t;

  typedef struct packed {
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
  } item_t;

  typedef struct packed {
    logic [2:0]  local_weekday;
    logic [10:0] local_minute_of_day;
    logic [13:0] minute_of_week;
    logic        dst_active;
  } res_t;

  // month offsets of the weekday formula, month 1..12
  function automatic logic [6:0] month_key(input logic [3:0] m);
    logic [6:0] k;
    case (m)
      4'd1:    k = 7'd98;
      4'd2:    k = 7'd101;
      4'd3:    k = 7'd100;
      4'd4:    k = 7'd61;
      4'd5:    k = 7'd112;
      4'd6:    k = 7'd101;
      4'd7:    k = 7'd110;
      4'd8:    k = 7'd43;
      4'd9:    k = 7'd109;
      4'd10:   k = 7'd97;
      4'd11:   k = 7'd100;
      4'd12:   k = 7'd46;
      default: k = 7'd45;
    endcase
    return k;
  endfunction

  // month 0..11
  function automatic logic [4:0] month_len(input logic [3:0] m0, input logic leap);
    logic [4:0] n;
    case (m0)
      4'd1:    n = leap ? 5'd29 : 5'd28;
      4'd3, 4'd5, 4'd8, 4'd10: n = 5'd30;
      default: n = 5'd31;
    endcase
    return n;
  endfunction

endpackage

// ----- rtl/core/local_time_with_dst_rule_unit.sv -----
// channel   dir  handshake                  payload
// s_axis    in   s_axis_tvalid/tready       utc date and time word
// m_axis    out  m_axis_tvalid/tready       local time word
// cfg       in   cfg_valid/cfg_ready        register index and data
//
// each valid rule costs a weekday lookup plus a day-by-day scan of the month,
// a rule with a field out of range finds no day and is skipped without a lookup,
// and the date itself needs one more weekday lookup
// next word is taken once the result has moved into the output register
// rst is synchronous; registers return to second sunday march to first
// sunday november with daylight saving off
module local_time_with_dst_rule_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // year, month, day, hour, minute
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // local_weekday, local_minute_of_day,
                                     // minute_of_week, dst_active
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [10:0] cfg_data
);

  ltdst_pkg::cfg_t  cfg;
  ltdst_pkg::item_t item;
  ltdst_pkg::res_t  res;
  logic             res_valid;
  logic             res_ready;

  assign cfg_ready   = 1'b1;
  assign item.year   = s_axis_tdata[13:0];
  assign item.month  = s_axis_tdata[17:14];
  assign item.day    = s_axis_tdata[22:18];
  assign item.hour   = s_axis_tdata[27:23];
  assign item.minute = s_axis_tdata[33:28];
  assign res_ready   = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.tz_offset_minutes  <= 11'sd0;
      cfg.dst_enable         <= 1'b0;
      cfg.dst_start_month    <= 4'd2;
      cfg.dst_start_weekday  <= 3'd0;
      cfg.dst_start_instance <= 3'd1;
      cfg.dst_end_month      <= 4'd10;
      cfg.dst_end_weekday    <= 3'd0;
      cfg.dst_end_instance   <= 3'd0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        ltdst_pkg::CfgTzOffset:  cfg.tz_offset_minutes  <= $signed(cfg_data);
        ltdst_pkg::CfgDstEnable: cfg.dst_enable         <= cfg_data[0];
        ltdst_pkg::CfgStartMon:  cfg.dst_start_month    <= cfg_data[3:0];
        ltdst_pkg::CfgStartWd:   cfg.dst_start_weekday  <= cfg_data[2:0];
        ltdst_pkg::CfgStartInst: cfg.dst_start_instance <= cfg_data[2:0];
        ltdst_pkg::CfgEndMon:    cfg.dst_end_month      <= cfg_data[3:0];
        ltdst_pkg::CfgEndWd:     cfg.dst_end_weekday    <= cfg_data[2:0];
        ltdst_pkg::CfgEndInst:   cfg.dst_end_instance   <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  ltdst_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_item   (item),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_axis_tvalid <= res_valid;
    end
    if (res_ready && res_valid) begin
      m_axis_tdata <= {3'b000, res.dst_active, res.minute_of_week,
                       res.local_minute_of_day, res.local_weekday};
    end
  end

endmodule

// ----- rtl/core/ltdst_dow.sv -----
module ltdst_dow (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [3:0]  month,
  input  logic [4:0]  day,
  input  logic [13:0] year,
  output logic        done,
  output logic [2:0]  weekday
);

  logic [4:0]  v;
  logic [13:0] s1_ya;
  logic [7:0]  s1_kd;
  logic [13:0] s2_ya;
  logic [11:0] s2_q4;
  logic [6:0]  s2_q100;
  logic [7:0]  s2_kd;
  logic [13:0] s3_sum;
  logic [13:0] s4_sum;
  logic [10:0] s4_q;
  logic [26:0] prod100;
  logic [27:0] prod7;
  logic [13:0] rem;

  assign prod100 = 27'(s1_ya) * 27'(ltdst_pkg::Recip100);
  assign prod7   = 28'(s3_sum) * 28'(ltdst_pkg::Recip7);
  assign rem     = s4_sum - 14'(s4_q) * 14'd7;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      v <= {v[3:0], start};
    end
    s1_ya   <= year - ((month < 4'd3) ? 14'd1 : 14'd0);
    s1_kd   <= 8'(ltdst_pkg::month_key(month)) + 8'(day);
    s2_ya   <= s1_ya;
    s2_q4   <= 12'(s1_ya >> 2);
    s2_q100 <= 7'(prod100 >> ltdst_pkg::Shift100);
    s2_kd   <= s1_kd;
    s3_sum  <= s2_ya + 14'(s2_q4) - 14'(s2_q100) + 14'(s2_q100 >> 2) + 14'(s2_kd);
    s4_sum  <= s3_sum;
    s4_q    <= 11'(prod7 >> ltdst_pkg::Shift7);
    // quotient is exact or one low
    weekday <= (rem >= 14'd7) ? 3'(rem - 14'd7) : 3'(rem);
  end

  assign done = v[4];

endmodule

// ----- rtl/core/ltdst_core.sv -----
module ltdst_core (
  input  logic              clk,
  input  logic              rst,
  input  ltdst_pkg::cfg_t   cfg,
  input  logic              in_valid,
  output logic              in_ready,
  input  ltdst_pkg::item_t  in_item,
  output logic              res_valid,
  input  logic              res_ready,
  output ltdst_pkg::res_t   res
);

  typedef enum logic [3:0] {
    S_IDLE, S_YDIV, S_YLEAP, S_RSETUP, S_RWAIT, S_RSCAN,
    S_DDOW, S_DWAIT, S_CALC, S_WRAP, S_MOW, S_DONE
  } state_t;

  state_t state;

  logic [13:0] y;
  logic [3:0]  m;
  logic [4:0]  d;
  logic [4:0]  h;
  logic [5:0]  mi;
  logic [6:0]  q100;
  logic        leap;
  logic        rsel;
  logic [4:0]  dc;
  logic [2:0]  wdc;
  logic [1:0]  left;
  logic [8:0]  start_val;
  logic [8:0]  end_val;
  logic        start_ok;
  logic        end_ok;
  logic [2:0]  dow;
  logic signed [12:0] modv;
  logic [10:0] lmod;
  logic        active;
  logic [13:0] mow;

  logic [3:0]  rm0;
  logic [2:0]  rwd;
  logic [2:0]  rinst;
  logic        rlast;
  logic        rvalid;
  logic [4:0]  rlen;
  logic [8:0]  rval;
  logic        match;
  logic        hit;
  logic        scan_end;

  logic        dow_start;
  logic [3:0]  dow_month;
  logic [4:0]  dow_day;
  logic        dow_done;
  logic [2:0]  dow_wd;

  logic [13:0] ys;
  logic [3:0]  ms;
  logic [26:0] yprod;
  logic        both_ok;
  logic [8:0]  lo;
  logic [8:0]  hi;
  logic [8:0]  cur;
  logic        act;
  logic signed [10:0] tzc;
  logic [10:0] hm;

  always_comb begin
    rm0    = rsel ? cfg.dst_end_month    : cfg.dst_start_month;
    rwd    = rsel ? cfg.dst_end_weekday  : cfg.dst_start_weekday;
    rinst  = rsel ? cfg.dst_end_instance : cfg.dst_start_instance;
    rlast  = (rinst == ltdst_pkg::InstLast);
    rvalid = (rm0 <= ltdst_pkg::MonthLast) && (rwd != ltdst_pkg::WdNone) &&
             (rinst <= ltdst_pkg::InstLast);
    rlen   = ltdst_pkg::month_len(rm0, leap);
    rval   = 9'(rm0 + 4'd1) * ltdst_pkg::DaysBase + 9'(dc);
    match  = (wdc == rwd);
    hit    = match && (rlast || left == 2'd0);
    scan_end = rlast ? (dc == 5'd1) : (dc == rlen);

    dow_start = (state == S_RSETUP && rvalid) || (state == S_DDOW);
    dow_month = (state == S_DDOW) ? m : rm0 + 4'd1;
    dow_day   = (state == S_DDOW) ? d : (rlast ? rlen : 5'd1);

    ys = in_item.year;
    if (ys < ltdst_pkg::YearMin) ys = ltdst_pkg::YearMin;
    if (ys > ltdst_pkg::YearMax) ys = ltdst_pkg::YearMax;
    ms = in_item.month;
    if (ms < 4'd1)  ms = 4'd1;
    if (ms > 4'd12) ms = 4'd12;
    yprod = 27'(y) * 27'(ltdst_pkg::Recip100);

    both_ok = start_ok && end_ok;
    lo  = both_ok ? start_val : 9'd0;
    hi  = both_ok ? end_val : 9'd0;
    cur = 9'(m) * ltdst_pkg::DaysBase + 9'(d);
    act = cfg.dst_enable && (cur >= lo) && (cur < hi);
    tzc = cfg.tz_offset_minutes;
    if (tzc < -$signed(ltdst_pkg::TzLimit)) tzc = -$signed(ltdst_pkg::TzLimit);
    if (tzc > $signed(ltdst_pkg::TzLimit))  tzc = $signed(ltdst_pkg::TzLimit);
    hm = 11'(h) * ltdst_pkg::MinPerHour + 11'(mi);
  end

  ltdst_dow u_dow (
    .clk     (clk),
    .rst     (rst),
    .start   (dow_start),
    .month   (dow_month),
    .day     (dow_day),
    .year    (y),
    .done    (dow_done),
    .weekday (dow_wd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      rsel  <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            y  <= ys;
            m  <= ms;
            d  <= in_item.day;
            h  <= (in_item.hour > 5'd23) ? 5'd23 : in_item.hour;
            mi <= (in_item.minute > 6'd59) ? 6'd59 : in_item.minute;
            state <= S_YDIV;
          end
        end
        S_YDIV: begin
          q100  <= 7'(yprod >> ltdst_pkg::Shift100);
          state <= S_YLEAP;
        end
        S_YLEAP: begin
          // century years are leap only when divisible by 400
          if (y == 14'(q100) * 14'd100) begin
            leap <= (q100[1:0] == 2'd0);
          end else begin
            leap <= (y[1:0] == 2'd0);
          end
          rsel  <= 1'b0;
          state <= S_RSETUP;
        end
        S_RSETUP: begin
          dc   <= rlast ? rlen : 5'd1;
          left <= rinst[1:0];
          if (rvalid) begin
            state <= S_RWAIT;
          end else begin
            if (rsel) end_ok <= 1'b0;
            else start_ok <= 1'b0;
            rsel  <= 1'b1;
            state <= rsel ? S_DDOW : S_RSETUP;
          end
        end
        S_RWAIT: begin
          if (dow_done) begin
            wdc   <= dow_wd;
            state <= S_RSCAN;
          end
        end
        S_RSCAN: begin
          if (hit || scan_end) begin
            if (rsel) begin
              end_ok  <= hit;
              end_val <= rval;
            end else begin
              start_ok  <= hit;
              start_val <= rval;
            end
            rsel  <= 1'b1;
            state <= rsel ? S_DDOW : S_RSETUP;
          end else begin
            if (match) left <= left - 2'd1;
            if (rlast) begin
              dc  <= dc - 5'd1;
              wdc <= (wdc == 3'd0) ? 3'd6 : wdc - 3'd1;
            end else begin
              dc  <= dc + 5'd1;
              wdc <= (wdc == 3'd6) ? 3'd0 : wdc + 3'd1;
            end
          end
        end
        S_DDOW: begin
          state <= S_DWAIT;
        end
        S_DWAIT: begin
          if (dow_done) begin
            dow   <= dow_wd;
            state <= S_CALC;
          end
        end
        S_CALC: begin
          active <= act;
          modv   <= $signed({2'b00, hm}) + 13'(tzc) + (act ? 13'sd60 : 13'sd0);
          state  <= S_WRAP;
        end
        S_WRAP: begin
          if (modv < 13'sd0) begin
            lmod <= 11'(modv + $signed(ltdst_pkg::MinPerDay));
            dow  <= (dow == 3'd0) ? 3'd6 : dow - 3'd1;
          end else if (modv >= $signed(ltdst_pkg::MinPerDay)) begin
            lmod <= 11'(modv - $signed(ltdst_pkg::MinPerDay));
            dow  <= (dow == 3'd6) ? 3'd0 : dow + 3'd1;
          end else begin
            lmod <= 11'(modv);
          end
          state <= S_MOW;
        end
        S_MOW: begin
          mow   <= 14'(dow) * 14'(ltdst_pkg::MinPerDay) + 14'(lmod);
          state <= S_DONE;
        end
        S_DONE: begin
          if (res_ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign in_ready  = (state == S_IDLE);
  assign res_valid = (state == S_DONE);
  assign res.local_weekday       = dow;
  assign res.local_minute_of_day = lmod;
  assign res.minute_of_week      = mow;
  assign res.dst_active          = active;

endmodule

// ----- bench/local_time_with_dst_rule_unit_test.sv -----
`timescale 1ns / 1ps

module local_time_with_dst_rule_unit_test;

  localparam int MinHour = 60;
  localparam int MinDay = 1440;
  localparam int MinWeek = 10080;
  localparam int HoldCycles = 400;
  localparam int TailCycles = 200;
  localparam int CycleLimit = 1000000;
  localparam int Phases = 11;
  localparam int PhaseItems = 105;
  localparam logic [8*13-1:0] MonthKey = "-bed=pen+mad.";

  typedef struct {
    bit                 is_write;
    logic [2:0]         idx;
    logic [10:0]        val;
    ltdst_pkg::item_t   utc;
    bit                 typed;
    ltdst_pkg::res_t    want;
  } plan_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;  // year, month, day, hour, minute
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;       // local_weekday, local_minute_of_day,
                                   // minute_of_week, dst_active
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [10:0] cfg_data = '0;

  ltdst_pkg::cfg_t clock_cfg;
  ltdst_pkg::res_t expected_times[$];
  plan_row_t       plan[$];
  int              fails = 0;
  int              idle_pct = 0;
  int              hold_seq = 0;
  int              cycles = 0;

  local_time_with_dst_rule_unit dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int unsigned weekday_from(int unsigned m, int unsigned d, int unsigned y);
    int unsigned k;
    k = MonthKey[8*(12-m) +: 8];
    if (m < 3) y = y - 1;
    return (y + y / 4 - y / 100 + y / 400 + k + d) % 7;
  endfunction

  function automatic int unsigned month_days(int unsigned m0, int unsigned y);
    bit leap;
    leap = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    if (m0 == 1) return leap ? 29 : 28;
    if (m0 == 3 || m0 == 5 || m0 == 8 || m0 == 10) return 30;
    return 31;
  endfunction

  // boundary coded as (month + 1) * 31 + day
  function automatic bit rule_day(input logic [3:0] m0, input logic [2:0] wd,
                                  input logic [2:0] inst, input int unsigned y,
                                  output int unsigned code);
    int unsigned len;
    int unsigned left;
    code = 0;
    if (m0 > 11) return 1'b0;
    len = month_days(m0, y);
    if (inst == ltdst_pkg::InstLast) begin
      for (int d = len; d > 0; d--) begin
        if (weekday_from(m0 + 1, d, y) == wd) begin
          code = (m0 + 1) * 31 + d;
          return 1'b1;
        end
      end
      return 1'b0;
    end
    left = inst + 1;
    for (int d = 1; d <= len; d++) begin
      if (weekday_from(m0 + 1, d, y) == wd) begin
        left--;
        if (left == 0) begin
          code = (m0 + 1) * 31 + d;
          return 1'b1;
        end
      end
    end
    return 1'b0;
  endfunction

  function automatic ltdst_pkg::res_t local_time(input ltdst_pkg::item_t utc,
                                                 input ltdst_pkg::cfg_t c);
    int unsigned     y, m, d, h, mi, start_code, stop_code, cur, dow;
    int              tz, mins;
    bit              ok_start, ok_stop, active;
    ltdst_pkg::res_t r;
    y = utc.year;
    m = utc.month;
    d = utc.day;
    h = utc.hour;
    mi = utc.minute;
    tz = $signed(c.tz_offset_minutes);
    if (y < 1970) y = 1970;
    if (y > 9999) y = 9999;
    if (m < 1) m = 1;
    if (m > 12) m = 12;
    if (h > 23) h = 23;
    if (mi > 59) mi = 59;
    if (tz < -840) tz = -840;
    if (tz > 840) tz = 840;
    ok_start = rule_day(c.dst_start_month, c.dst_start_weekday, c.dst_start_instance,
                        y, start_code);
    ok_stop = rule_day(c.dst_end_month, c.dst_end_weekday, c.dst_end_instance, y, stop_code);
    if (!(ok_start && ok_stop)) begin
      start_code = 0;
      stop_code = 0;
    end
    dow = weekday_from(m, d, y);
    mins = int'(h * MinHour + mi) + tz;
    cur = m * 31 + d;
    active = c.dst_enable && cur >= start_code && cur < stop_code;
    if (active) mins += MinHour;
    if (mins < 0) begin
      mins += MinDay;
      dow = (dow + 6) % 7;
    end
    if (mins >= MinDay) begin
      mins -= MinDay;
      dow = (dow + 1) % 7;
    end
    r.local_weekday = 3'(dow);
    r.local_minute_of_day = 11'(mins);
    r.minute_of_week = 14'((dow * MinDay + mins) % MinWeek);
    r.dst_active = active;
    return r;
  endfunction

  function automatic logic [39:0] pack_utc(input ltdst_pkg::item_t utc);
    return {6'd0, utc.minute, utc.hour, utc.day, utc.month, utc.year};
  endfunction

  function automatic plan_row_t plan_time(int y, int m, int d, int h, int mi);
    plan_row_t p;
    p = '{default: '0};
    p.utc = '{year: 14'(y), month: 4'(m), day: 5'(d), hour: 5'(h), minute: 6'(mi)};
    return p;
  endfunction

  function automatic plan_row_t plan_known(int y, int m, int d, int h, int mi,
                                           ltdst_pkg::res_t want);
    plan_row_t p;
    p = plan_time(y, m, d, h, mi);
    p.typed = 1'b1;
    p.want = want;
    return p;
  endfunction

  function automatic plan_row_t plan_reg(logic [2:0] idx, logic [10:0] val);
    plan_row_t p;
    p = '{default: '0};
    p.is_write = 1'b1;
    p.idx = idx;
    p.val = val;
    return p;
  endfunction

  function automatic ltdst_pkg::item_t pick_time(input ltdst_pkg::cfg_t c);
    ltdst_pkg::item_t u;
    int               r;
    r = $urandom_range(0, 19);
    if (r == 0) u.year = 14'($urandom);
    else if (r == 1) u.year = 14'($urandom_range(0, 1969));
    else if (r == 2) u.year = 14'($urandom_range(10000, 16383));
    else u.year = 14'($urandom_range(1970, 2400));
    r = $urandom_range(0, 9);
    if (r == 0) u.month = 4'($urandom);
    else if (r < 3 && c.dst_start_month <= ltdst_pkg::MonthLast)
      u.month = 4'(c.dst_start_month + 4'd1);
    else if (r < 5 && c.dst_end_month <= ltdst_pkg::MonthLast)
      u.month = 4'(c.dst_end_month + 4'd1);
    else u.month = 4'($urandom_range(1, 12));
    u.day = ($urandom_range(0, 19) == 0) ? 5'd0 : 5'($urandom_range(1, 31));
    u.hour = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(24, 31)) : 5'($urandom_range(0, 23));
    u.minute = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(60, 63))
                                           : 6'($urandom_range(0, 59));
    return u;
  endfunction

  task automatic send_time(input ltdst_pkg::item_t utc, input bit typed,
                           input ltdst_pkg::res_t want);
    s_axis_tdata <= pack_utc(utc);
    s_axis_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    expected_times.push_back(typed ? want : local_time(utc, clock_cfg));
    if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (expected_times.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // leaves cfg_valid high so back-to-back writes keep it asserted
  task automatic write_reg(input logic [2:0] idx, input logic [10:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      ltdst_pkg::CfgTzOffset:  clock_cfg.tz_offset_minutes = val;
      ltdst_pkg::CfgDstEnable: clock_cfg.dst_enable = val[0];
      ltdst_pkg::CfgStartMon:  clock_cfg.dst_start_month = val[3:0];
      ltdst_pkg::CfgStartWd:   clock_cfg.dst_start_weekday = val[2:0];
      ltdst_pkg::CfgStartInst: clock_cfg.dst_start_instance = val[2:0];
      ltdst_pkg::CfgEndMon:    clock_cfg.dst_end_month = val[3:0];
      ltdst_pkg::CfgEndWd:     clock_cfg.dst_end_weekday = val[2:0];
      ltdst_pkg::CfgEndInst:   clock_cfg.dst_end_instance = val[2:0];
      default: ;
    endcase
  endtask

  task automatic retune(input int phase);
    logic [10:0] tz;
    logic [3:0]  sm, em;
    logic [2:0]  sw, ew, si, ei;
    int          pick;
    pick = $urandom_range(0, 5);
    if (phase == 0 || pick == 0) tz = 11'd840;
    else if (phase == 1 || pick == 1) tz = -11'sd840;
    else if (pick == 2) tz = 11'($urandom);
    else tz = 11'($urandom_range(0, 1680) - 840);
    if ($urandom_range(0, 9) == 0) begin
      sm = 4'($urandom);
      em = 4'($urandom);
    end else if (phase % 2 == 0) begin
      sm = 4'($urandom_range(0, 5));
      em = 4'($urandom_range(6, 11));
    end else begin
      sm = 4'($urandom_range(0, 11));
      em = 4'($urandom_range(0, 11));
    end
    sw = ($urandom_range(0, 9) == 0) ? ltdst_pkg::WdNone : 3'($urandom_range(0, 6));
    ew = ($urandom_range(0, 9) == 0) ? ltdst_pkg::WdNone : 3'($urandom_range(0, 6));
    si = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
    ei = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
    settle();
    write_reg(ltdst_pkg::CfgTzOffset, tz);
    write_reg(ltdst_pkg::CfgDstEnable, {10'($urandom), ($urandom_range(0, 4) != 0)});
    write_reg(ltdst_pkg::CfgStartMon, {7'($urandom), sm});
    write_reg(ltdst_pkg::CfgStartWd, {8'($urandom), sw});
    write_reg(ltdst_pkg::CfgStartInst, {8'($urandom), si});
    write_reg(ltdst_pkg::CfgEndMon, {7'($urandom), em});
    write_reg(ltdst_pkg::CfgEndWd, {8'($urandom), ew});
    write_reg(ltdst_pkg::CfgEndInst, {8'($urandom), ei});
    cfg_valid <= 1'b0;
  endtask

  task automatic check_time(input logic [31:0] word);
    ltdst_pkg::res_t got, want;
    got.local_weekday = word[2:0];
    got.local_minute_of_day = word[13:3];
    got.minute_of_week = word[27:14];
    got.dst_active = word[28];
    if (expected_times.size() == 0) begin
      $error("local time word with nothing expected: %h", word);
      fails++;
      return;
    end
    want = expected_times.pop_front();
    if (got.local_weekday !== want.local_weekday) begin
      $error("local_weekday: expected %0d, got %0d", want.local_weekday, got.local_weekday);
      fails++;
    end
    if (got.local_minute_of_day !== want.local_minute_of_day) begin
      $error("local_minute_of_day: expected %0d, got %0d",
             want.local_minute_of_day, got.local_minute_of_day);
      fails++;
    end
    if (got.minute_of_week !== want.minute_of_week) begin
      $error("minute_of_week: expected %0d, got %0d", want.minute_of_week, got.minute_of_week);
      fails++;
    end
    if (got.dst_active !== want.dst_active) begin
      $error("dst_active: expected %0d, got %0d", want.dst_active, got.dst_active);
      fails++;
    end
  endtask

  // output side: random stalls plus a long hold-off on request
  initial begin
    int stall_left;
    int hold_left;
    int hold_seen;
    stall_left = 0;
    hold_left = 0;
    hold_seen = 0;
    while (rst) @(posedge clk);
    forever begin
      @(posedge clk);
      if (m_axis_tvalid && m_axis_tready) check_time(m_axis_tdata);
      if (hold_seen != hold_seq) begin
        hold_seen = hold_seq;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct / 2) begin
        stall_left = $urandom_range(1, 9) - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CycleLimit) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    clock_cfg = '{tz_offset_minutes: 11'sd0, dst_enable: 1'b0, dst_start_month: 4'd2,
                  dst_start_weekday: 3'd0, dst_start_instance: 3'd1, dst_end_month: 4'd10,
                  dst_end_weekday: 3'd0, dst_end_instance: 3'd0};

    // reset rules, no offset
    plan.push_back(plan_known(1970, 1, 1, 0, 0, '{3'd4, 11'd0, 14'd5760, 1'b0}));
    plan.push_back(plan_known(0, 0, 1, 0, 0, '{3'd4, 11'd0, 14'd5760, 1'b0}));
    plan.push_back(plan_known(16383, 15, 31, 31, 63, '{3'd5, 11'd1439, 14'd8639, 1'b0}));
    plan.push_back(plan_time(2024, 3, 0, 12, 0));
    plan.push_back(plan_time(2024, 13, 15, 10, 30));
    // largest offset, dst on: next-day wrap and both rule edges
    plan.push_back(plan_reg(ltdst_pkg::CfgTzOffset, 11'd840));
    plan.push_back(plan_reg(ltdst_pkg::CfgDstEnable, 11'd1));
    plan.push_back(plan_time(2024, 7, 4, 23, 59));
    plan.push_back(plan_time(2024, 3, 10, 1, 0));
    plan.push_back(plan_time(2024, 3, 9, 23, 0));
    plan.push_back(plan_time(2024, 11, 3, 5, 0));
    plan.push_back(plan_time(2024, 11, 2, 5, 0));
    plan.push_back(plan_reg(ltdst_pkg::CfgTzOffset, -11'sd840));
    plan.push_back(plan_time(2000, 1, 1, 0, 0));
    plan.push_back(plan_time(1969, 6, 15, 3, 0));
    plan.push_back(plan_time(10000, 6, 15, 3, 0));
    // offsets beyond range
    plan.push_back(plan_reg(ltdst_pkg::CfgTzOffset, 11'd1023));
    plan.push_back(plan_time(2030, 8, 20, 23, 30));
    plan.push_back(plan_reg(ltdst_pkg::CfgTzOffset, 11'h400));
    plan.push_back(plan_time(2030, 8, 20, 0, 10));
    // last monday of february to fourth saturday of december
    plan.push_back(plan_reg(ltdst_pkg::CfgTzOffset, 11'd0));
    plan.push_back(plan_reg(ltdst_pkg::CfgStartMon, 11'd1));
    plan.push_back(plan_reg(ltdst_pkg::CfgStartWd, 11'd1));
    plan.push_back(plan_reg(ltdst_pkg::CfgStartInst, 11'd4));
    plan.push_back(plan_reg(ltdst_pkg::CfgEndMon, 11'd11));
    plan.push_back(plan_reg(ltdst_pkg::CfgEndWd, 11'd6));
    plan.push_back(plan_reg(ltdst_pkg::CfgEndInst, 11'd3));
    plan.push_back(plan_time(2024, 2, 26, 12, 0));
    plan.push_back(plan_time(2023, 2, 27, 12, 0));
    plan.push_back(plan_time(2100, 2, 22, 12, 0));
    plan.push_back(plan_time(2000, 12, 23, 12, 0));
    // rules that find no day
    plan.push_back(plan_reg(ltdst_pkg::CfgStartMon, 11'd15));
    plan.push_back(plan_time(2024, 6, 1, 12, 0));
    plan.push_back(plan_reg(ltdst_pkg::CfgStartMon, 11'd2));
    plan.push_back(plan_reg(ltdst_pkg::CfgStartWd, 11'd7));
    plan.push_back(plan_time(2024, 6, 1, 12, 0));
    plan.push_back(plan_reg(ltdst_pkg::CfgStartWd, 11'd0));
    plan.push_back(plan_reg(ltdst_pkg::CfgStartInst, 11'd6));
    plan.push_back(plan_time(2024, 6, 1, 12, 0));

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    idle_pct = 20;
    for (int i = 0; i < plan.size(); i++) begin
      if (plan[i].is_write) begin
        if (i == 0 || !plan[i-1].is_write) settle();
        write_reg(plan[i].idx, plan[i].val);
        if (i + 1 == plan.size() || !plan[i+1].is_write) cfg_valid <= 1'b0;
      end else begin
        send_time(plan[i].utc, plan[i].typed, plan[i].want);
      end
    end

    for (int phase = 0; phase < Phases; phase++) begin
      retune(phase);
      if (phase >= Phases - 2) idle_pct = 0;
      else if (phase % 4 == 3) idle_pct = 0;
      else idle_pct = 25;
      if (phase == 2) hold_seq++;
      for (int n = 0; n < PhaseItems; n++) send_time(pick_time(clock_cfg), 1'b0, '0);
    end

    s_axis_tvalid <= 1'b0;
    while (expected_times.size() != 0) @(posedge clk);
    repeat (TailCycles) @(posedge clk);
    if (fails == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/ltdst_pkg.sv
rtl/core/ltdst_dow.sv
rtl/core/ltdst_core.sv
rtl/core/local_time_with_dst_rule_unit.sv
bench/local_time_with_dst_rule_unit_test.sv
